// ===== design/mat2i_pkg.sv =====
// ----------------------------------------------------------------------------
// mat2i_pkg
// Shared constants and types for the 2x2 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mat2i_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int D2_W          = 65;   // twice |det|; |det| fits 64 bits unsigned
    localparam int Q_W           = 34;   // quotient bits 33..0, bit 33 flags overflow
    localparam int REM_W         = 100;  // holds numerator and divisor << 33
    localparam int N_CELLS       = Q_W;
    localparam logic [DATA_W-1:0] EPS_RESET = 32'd4295;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } lane_t;

    typedef lane_t [3:0] lanes_t;

    typedef struct packed {
        logic            singular;
        logic [3:0]      rneg;
        logic [D2_W-1:0] d2;
    } ctl_t;

endpackage

// ===== design/mat2i_cell.sv =====
// ----------------------------------------------------------------------------
// mat2i_cell
// One restoring division step for all four elements: decides quotient bit K.
// ----------------------------------------------------------------------------
module mat2i_cell #(
    parameter int K = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mat2i_pkg::ctl_t   in_ctl,
    input  mat2i_pkg::lanes_t in_lanes,
    output logic              out_valid,
    output mat2i_pkg::ctl_t   out_ctl,
    output mat2i_pkg::lanes_t out_lanes
);
    import mat2i_pkg::*;

    logic             valid_reg;
    ctl_t             ctl_reg;
    lanes_t           lanes_reg;
    lanes_t           lanes_next;
    logic [REM_W-1:0] dshift;
    logic [REM_W:0]   diff [4];

    assign dshift = REM_W'(in_ctl.d2) << K;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            diff[i]       = {1'b0, in_lanes[i].rem} - {1'b0, dshift};
            lanes_next[i] = in_lanes[i];
            if (!diff[i][REM_W])
            begin
                lanes_next[i].rem  = diff[i][REM_W-1:0];
                lanes_next[i].q[K] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg   <= in_ctl;
        lanes_reg <= lanes_next;
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_lanes = lanes_reg;

endmodule

// ===== design/matrix2x2_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix2x2_inverse
// Inverts one signed fixed-point 2x2 matrix per cycle through a division chain.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer when       Signals
// input     in         start && !busy      a11 a12 a21 a22
// result    out        done                r11 r12 r21 r22 singular saturated
// config    in         cfg_we              cfg_wdata (det_epsilon)
//
// A new matrix is taken every cycle; busy is always low.
// The result passes through registered stages: products, determinant, numerators,
// then 34 division cells (one quotient bit each), then rounding/saturation.
// Reset clears the pipeline valid bits and sets det_epsilon to 4295.
// The receiver cannot stall; results stream out in order.
// ----------------------------------------------------------------------------
module matrix2x2_inverse #(
    parameter int FRAC_BITS = mat2i_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] a11,
    input  logic signed [31:0] a12,
    input  logic signed [31:0] a21,
    input  logic signed [31:0] a22,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic        done,
    output logic signed [31:0] r11,
    output logic signed [31:0] r12,
    output logic signed [31:0] r21,
    output logic signed [31:0] r22,
    output logic        singular,
    output logic        saturated
);
    import mat2i_pkg::*;

    localparam int LATENCY = N_CELLS + 4;
    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic [DATA_W-1:0] eps_reg;

    // stage 0: products
    logic                     v0_reg;
    logic signed [DATA_W-1:0] e0_reg [4];   // adjugate order: a22 a12 a21 a11
    logic signed [63:0]       p1_reg, p2_reg;

    // stage 1: determinant
    logic                     v1_reg;
    logic signed [DATA_W-1:0] e1_reg [4];
    logic signed [64:0]       det_reg;

    // stage 2: numerators
    logic                     v2_reg;
    ctl_t                     ctl2_reg;
    ctl_t                     ctl2_next;
    lanes_t                   lanes2_reg;
    lanes_t                   lanes2_next;
    logic                     dneg;
    logic [63:0]              dmag;

    logic   chain_v     [N_CELLS+1];
    ctl_t   chain_ctl   [N_CELLS+1];
    lanes_t chain_lanes [N_CELLS+1];

    logic [DATA_W-1:0] res_next [4];
    logic              sat_next;

    logic              done_reg;
    logic [DATA_W-1:0] r_reg [4];
    logic              sing_reg, sat_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= EPS_RESET;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                eps_reg <= cfg_wdata;
            end
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            done_reg <= chain_v[N_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg[0] <= a22;
        e0_reg[1] <= a12;
        e0_reg[2] <= a21;
        e0_reg[3] <= a11;
        p1_reg    <= a11 * a22;
        p2_reg    <= a12 * a21;
        e1_reg    <= e0_reg;
        det_reg   <= 65'(p1_reg) - 65'(p2_reg);
    end

    assign dneg = det_reg[64];
    assign dmag = dneg ? 64'(-det_reg) : det_reg[63:0];

    always_comb
    begin
        logic        aneg;
        logic [31:0] mag;
        ctl2_next.singular = (dmag <= 64'(eps_reg));
        ctl2_next.d2       = {dmag, 1'b0};
        for (int i = 0; i < 4; i++)
        begin
            aneg = e1_reg[i][DATA_W-1];
            mag  = aneg ? 32'(-e1_reg[i]) : e1_reg[i];
            // off-diagonal adjugate terms are negated
            ctl2_next.rneg[i]   = aneg ^ dneg ^ ((i == 1) || (i == 2));
            lanes2_next[i].rem  = (REM_W'(mag) << (2 * FRAC_BITS + 1)) + REM_W'(dmag);
            lanes2_next[i].q    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl2_reg   <= ctl2_next;
        lanes2_reg <= lanes2_next;
    end

    assign chain_v[0]     = v2_reg;
    assign chain_ctl[0]   = ctl2_reg;
    assign chain_lanes[0] = lanes2_reg;

    for (genvar g = 0; g < N_CELLS; g++)
    begin : g_cell
        mat2i_cell #(.K(N_CELLS - 1 - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_v[g]),
            .in_ctl    (chain_ctl[g]),
            .in_lanes  (chain_lanes[g]),
            .out_valid (chain_v[g+1]),
            .out_ctl   (chain_ctl[g+1]),
            .out_lanes (chain_lanes[g+1])
        );
    end

    always_comb
    begin
        logic [Q_W-1:0]    q;
        logic              clip;
        logic [DATA_W-1:0] m;
        sat_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            q = chain_lanes[N_CELLS][i].q;
            m = '0;
            if (chain_ctl[N_CELLS].rneg[i])
            begin
                clip        = q[33] | q[32] | (q[31] & (|q[30:0]));
                m           = clip ? 32'h8000_0000 : q[31:0];
                res_next[i] = -m;
            end
            else
            begin
                clip        = q[33] | q[32] | q[31];
                res_next[i] = clip ? 32'h7FFF_FFFF : q[31:0];
            end
            sat_next = sat_next | clip;
        end
        if (chain_ctl[N_CELLS].singular)
        begin
            res_next[0] = ONE;
            res_next[1] = '0;
            res_next[2] = '0;
            res_next[3] = ONE;
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= res_next;
        sing_reg <= chain_ctl[N_CELLS].singular;
        sat_reg  <= sat_next;
    end

    assign done      = done_reg;
    assign r11       = r_reg[0];
    assign r12       = r_reg[1];
    assign r21       = r_reg[2];
    assign r22       = r_reg[3];
    assign singular  = sing_reg;
    assign saturated = sat_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result missing after fixed latency");

    a_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        done && singular |-> !saturated && r11 == ONE && r12 == 0)
        else $error("singular result is not identity");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching transfer");

endmodule

// ===== tb/matrix2x2_inverse_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix2x2_inverse_tb
// Streams 2x2 Q16.16 matrices through the inverter with random start gaps and
// checks every result against a fixed-point inverse computed here. Sweeps the
// singular threshold across reset, zero, small, large and all-ones values.
// ----------------------------------------------------------------------------
module matrix2x2_inverse_tb;

    localparam int FRAC = mat2i_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 38;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] a11, a12, a21, a22;
    } matrix_t;

    typedef struct packed {
        logic signed [31:0] r11, r12, r21, r22;
        logic singular, saturated;
    } inverse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] a11 = '0, a12 = '0, a21 = '0, a22 = '0;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic done;
    logic signed [31:0] r11, r12, r21, r22;
    logic singular, saturated;

    matrix_t  pending_q[$];
    inverse_t expected_q[$];
    logic [31:0] eps = mat2i_pkg::EPS_RESET;
    int gap_left = 0;
    int mismatches = 0;
    int cycles = 0;
    bit feeding = 1'b0;

    matrix2x2_inverse i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a11(a11), .a12(a12), .a21(a21), .a22(a22),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .r11(r11), .r12(r12), .r21(r21), .r22(r22),
        .singular(singular), .saturated(saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one element of adj/det, rounded half away from zero, saturated
    function automatic logic [31:0] scaled_element(logic signed [63:0] adj,
                                                   logic signed [63:0] det,
                                                   inout logic sat);
        logic [127:0] num, dmag, q;
        logic neg;
        begin
            neg = (adj < 0) != (det < 0);
            num = (adj < 0) ? 128'(-adj) : 128'(adj);
            dmag = (det < 0) ? 128'(-det) : 128'(det);
            num = num << (2 * FRAC);
            q = (2 * num + dmag) / (2 * dmag);
            if (neg)
            begin
                if (q > 128'h8000_0000)
                begin
                    sat = 1'b1;
                    q = 128'h8000_0000;
                end
                return 32'(-q);
            end
            if (q > 128'h7FFF_FFFF)
            begin
                sat = 1'b1;
                q = 128'h7FFF_FFFF;
            end
            return q[31:0];
        end
    endfunction

    function automatic inverse_t invert(matrix_t m);
        inverse_t r;
        logic signed [63:0] det, dabs;
        logic sat;
        begin
            det = 64'(m.a11) * 64'(m.a22) - 64'(m.a12) * 64'(m.a21);
            dabs = (det < 0) ? -det : det;
            sat = 1'b0;
            if ($unsigned(dabs) <= {32'd0, eps})
            begin
                r.r11 = 32'sd1 <<< FRAC;
                r.r12 = '0;
                r.r21 = '0;
                r.r22 = 32'sd1 <<< FRAC;
                r.singular = 1'b1;
                r.saturated = 1'b0;
                return r;
            end
            r.r11 = scaled_element(64'(m.a22), det, sat);
            r.r12 = scaled_element(-64'(m.a12), det, sat);
            r.r21 = scaled_element(-64'(m.a21), det, sat);
            r.r22 = scaled_element(64'(m.a11), det, sat);
            r.singular = 1'b0;
            r.saturated = sat;
            return r;
        end
    endfunction

    function automatic int pick_gap();
        int p;
        begin
            p = $urandom_range(99);
            if (p < 45) return 0;
            if (p < 90) return $urandom_range(3);
            return $urandom_range(40);
        end
    endfunction

    function automatic logic [31:0] rand_elem();
        int p;
        begin
            p = $urandom_range(99);
            if (p < 40) return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            if (p < 60) return $urandom;
            if (p < 75) return $urandom_range(8) - 4;
            if (p < 85) return ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                               ^ $urandom_range(3);
            return $urandom_range(32'h0000_4000) - 32'h0000_2000;
        end
    endfunction

    // driver: start held only while items remain and no gap is running
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            expected_q.push_back(invert('{a11, a12, a21, a22}));
        if (rst_n && feeding && pending_q.size() > 0 && (!start || !busy))
        begin
            if (start && gap_left == 0)
                gap_left = pick_gap();
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else
            begin
                matrix_t m;
                m = pending_q.pop_front();
                a11 <= m.a11; a12 <= m.a12; a21 <= m.a21; a22 <= m.a22;
                start <= 1'b1;
                gap_left = pick_gap();
            end
        end
        else if (!start || !busy)
            start <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            inverse_t want, got;
            got = '{r11, r12, r21, r22, singular, saturated};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected r=%h %h %h %h s=%b t=%b got %h %h %h %h s=%b t=%b",
                                 want.r11, want.r12, want.r21, want.r22,
                                 want.singular, want.saturated, got.r11, got.r12,
                                 got.r21, got.r22, got.singular, got.saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("matrix2x2_inverse_tb failed");
            $finish;
        end
    end

    task automatic add(logic [31:0] x11, logic [31:0] x12,
                       logic [31:0] x21, logic [31:0] x22);
        pending_q.push_back('{x11, x12, x21, x22});
    endtask

    task automatic run_phase();
        begin
            feeding = 1'b1;
            while (pending_q.size() > 0)
                @(posedge clk);
            @(posedge clk);
            @(posedge clk);
            feeding = 1'b0;
            while (start || expected_q.size() > 0)
                @(posedge clk);
            repeat (LATENCY + 5) @(posedge clk);
        end
    endtask

    task automatic write_eps(logic [31:0] v);
        begin
            cfg_we <= 1'b1;
            cfg_wdata <= v;
            @(posedge clk);
            cfg_we <= 1'b0;
            eps = v;
            @(posedge clk);
        end
    endtask

    // singular-ish matrices: det near the threshold
    task automatic add_near_threshold();
        logic [31:0] s;
        begin
            s = $urandom_range(1, 300);
            add(s, $urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 300));
        end
    endtask

    initial
    begin
        logic [31:0] eps_set [5];
        eps_set = '{32'd0, 32'd1, 32'd65536, 32'hFFFF_FFFF, 32'd4295};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, zero, rank one, extremes, ties, saturation
        add(32'h0001_0000, 0, 0, 32'h0001_0000);
        add(0, 0, 0, 0);
        add(32'h0002_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
        add(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add(32'h8000_0000, 0, 0, 32'h8000_0000);
        add(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF);
        add(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        add(1, 0, 0, 1);
        add(32'h0000_0100, 0, 0, 32'h0000_0100);
        add(32'h0003_0000, 0, 0, 32'h0003_0000);
        add(0, 32'h0001_0000, 32'h0001_0000, 0);
        add(0, 32'hFFFF_0000, 32'h0001_0000, 0);
        add(32'h0000_0041, 0, 0, 32'h0000_0041);
        add(32'h0000_1000, 32'h0000_0FFF, 32'h0000_1000, 32'h0000_1000);
        add(32'h0002_0000, 32'h0000_8000, 32'hFFFF_8000, 32'hFFFE_0000);
        run_phase();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_eps(eps_set[ph] ^ ((ph == 2) ? $urandom_range(255) : 0));
            for (int i = 0; i < 360; i++)
            begin
                if ($urandom_range(9) == 0)
                    add_near_threshold();
                else
                    add(rand_elem(), rand_elem(), rand_elem(), rand_elem());
            end
            run_phase();
        end

        if (mismatches == 0)
            $display("matrix2x2_inverse_tb passed");
        else
            $display("matrix2x2_inverse_tb failed");
        $finish;
    end

endmodule

// ===== matrix2x2_inverse.f =====
design/mat2i_pkg.sv
design/mat2i_cell.sv
design/matrix2x2_inverse.sv
tb/matrix2x2_inverse_tb.sv
